@@ rtl/core/dlpb_pkg.sv @@
`default_nettype none

package dlpb_pkg;

    localparam int PRICE_BITS = 32;
    localparam int QTY_BITS   = 32;
    localparam int SEQ_BITS   = 32;
    localparam int LEVELS_W   = 5;
    localparam int DEPTH_W    = 5;

    localparam logic [1:0] KIND_UPDATE = 2'd0;
    localparam logic [1:0] KIND_QUERY  = 2'd1;
    localparam logic [1:0] KIND_RESET  = 2'd2;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_GAP    = 2'd1;
    localparam logic [1:0] STATUS_REJECT = 2'd2;

    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd16;

    typedef enum logic [1:0] {
        CELL_HOLD      = 2'd0,
        CELL_OVERWRITE = 2'd1,
        CELL_DELETE    = 2'd2,
        CELL_INSERT    = 2'd3
    } cell_op_t;

    typedef struct packed {
        logic [1:0]            kind;
        logic                  side;
        logic [SEQ_BITS-1:0]   seq_in;
        logic [PRICE_BITS-1:0] price;
        logic [QTY_BITS-1:0]   quantity;
    } req_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [QTY_BITS-1:0]   volume;
        logic                  bid_valid;
        logic [PRICE_BITS-1:0] best_bid_price;
        logic [QTY_BITS-1:0]   best_bid_qty;
        logic                  ask_valid;
        logic [PRICE_BITS-1:0] best_ask_price;
        logic [QTY_BITS-1:0]   best_ask_qty;
        logic [LEVELS_W-1:0]   bid_levels;
        logic [LEVELS_W-1:0]   ask_levels;
        logic [SEQ_BITS-1:0]   seq_out;
    } rsp_t;

    // carried along the cell row, best end first
    typedef struct packed {
        logic                found;
        logic                better;
        logic [QTY_BITS-1:0] vol;
    } chain_t;

    typedef struct packed {
        cell_op_t              op;
        logic                  sell;
        logic [PRICE_BITS-1:0] price;
        logic [QTY_BITS-1:0]   qty;
    } cell_ctrl_t;

    typedef struct packed {
        logic                  upd_en;
        logic                  clear;
        logic                  sell;
        logic [PRICE_BITS-1:0] price;
        logic [QTY_BITS-1:0]   qty;
    } side_cmd_t;

    typedef struct packed {
        logic                  ok;
        logic [QTY_BITS-1:0]   volume;
        logic                  top_valid;
        logic [PRICE_BITS-1:0] top_price;
        logic [QTY_BITS-1:0]   top_qty;
    } side_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/dlpb_cell.sv @@
`default_nettype none

module dlpb_cell #(
    parameter int MAX_DEPTH = 16,
    parameter int IDX       = 0,
    localparam int CW       = $clog2(MAX_DEPTH + 1)
) (
    input  wire logic                            clk,
    input  wire dlpb_pkg::cell_ctrl_t            ctrl,
    input  wire logic [CW-1:0]                   cnt,
    input  wire logic [CW-1:0]                   ins_cnt,
    input  wire logic [dlpb_pkg::PRICE_BITS-1:0] left_price,
    input  wire logic [dlpb_pkg::QTY_BITS-1:0]   left_qty,
    input  wire logic                            left_ge,
    input  wire logic [dlpb_pkg::PRICE_BITS-1:0] right_price,
    input  wire logic [dlpb_pkg::QTY_BITS-1:0]   right_qty,
    input  wire dlpb_pkg::chain_t                chain_in,
    output logic [dlpb_pkg::PRICE_BITS-1:0]      price,
    output logic [dlpb_pkg::QTY_BITS-1:0]        qty,
    output logic                                 ge,
    output dlpb_pkg::chain_t                     chain_out
);

    localparam logic [CW-1:0] IDX_V = CW'(IDX);

    logic [dlpb_pkg::PRICE_BITS-1:0] price_reg, price_next;
    logic [dlpb_pkg::QTY_BITS-1:0]   qty_reg, qty_next;
    logic occ, ins_occ, match, better;

    assign occ     = cnt > IDX_V;
    assign ins_occ = ins_cnt > IDX_V;
    assign match   = occ && (price_reg == ctrl.price);
    assign better  = ctrl.sell ? (ctrl.price < price_reg) : (ctrl.price > price_reg);

    // at or past the insert slot; monotone along the row as levels are sorted
    assign ge = !ins_occ || better;

    assign chain_out.found  = chain_in.found || match;
    assign chain_out.better = chain_in.better || (occ && better);
    assign chain_out.vol    = chain_in.vol | (match ? qty_reg : '0);

    always_comb
    begin
        price_next = price_reg;
        qty_next   = qty_reg;
        case (ctrl.op)
            dlpb_pkg::CELL_OVERWRITE:
            begin
                if (match)
                    qty_next = ctrl.qty;
            end
            dlpb_pkg::CELL_DELETE:
            begin
                // everything from the deleted level onwards moves up one
                if (chain_in.found || match)
                begin
                    price_next = right_price;
                    qty_next   = right_qty;
                end
            end
            dlpb_pkg::CELL_INSERT:
            begin
                if (ge && !left_ge)
                begin
                    price_next = ctrl.price;
                    qty_next   = ctrl.qty;
                end
                else if (ge)
                begin
                    price_next = left_price;
                    qty_next   = left_qty;
                end
            end
            default:
            begin
                price_next = price_reg;
                qty_next   = qty_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        price_reg <= price_next;
        qty_reg   <= qty_next;
    end

    assign price = price_reg;
    assign qty   = qty_reg;

endmodule

`default_nettype wire

@@ rtl/core/dlpb_side.sv @@
`default_nettype none

module dlpb_side #(
    parameter int MAX_DEPTH = 16,
    localparam int CW       = $clog2(MAX_DEPTH + 1)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dlpb_pkg::side_cmd_t  cmd,
    input  wire logic [CW-1:0]        depth,
    output dlpb_pkg::side_stat_t      stat,
    output logic [CW-1:0]             cnt
);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] ins_cnt;
    dlpb_pkg::cell_op_t   act;
    dlpb_pkg::cell_ctrl_t ctrl;
    logic ok, evict, commit;

    logic [dlpb_pkg::PRICE_BITS-1:0] price_w [MAX_DEPTH];
    logic [dlpb_pkg::QTY_BITS-1:0]   qty_w   [MAX_DEPTH];
    logic                            ge_w    [MAX_DEPTH];
    dlpb_pkg::chain_t                chain_w [MAX_DEPTH+1];

    assign chain_w[0] = '0;

    for (genvar gi = 0; gi < MAX_DEPTH; gi++)
    begin : g_cell
        dlpb_cell #(
            .MAX_DEPTH(MAX_DEPTH),
            .IDX      (gi)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .cnt        (cnt_reg),
            .ins_cnt    (ins_cnt),
            .left_price ((gi == 0) ? '0 : price_w[(gi == 0) ? 0 : gi-1]),
            .left_qty   ((gi == 0) ? '0 : qty_w[(gi == 0) ? 0 : gi-1]),
            .left_ge    ((gi == 0) ? 1'b0 : ge_w[(gi == 0) ? 0 : gi-1]),
            .right_price(price_w[(gi == MAX_DEPTH-1) ? gi : gi+1]),
            .right_qty  (qty_w[(gi == MAX_DEPTH-1) ? gi : gi+1]),
            .chain_in   (chain_w[gi]),
            .price      (price_w[gi]),
            .qty        (qty_w[gi]),
            .ge         (ge_w[gi]),
            .chain_out  (chain_w[gi+1])
        );
    end

    always_comb
    begin
        act     = dlpb_pkg::CELL_HOLD;
        ok      = 1'b0;
        evict   = 1'b0;
        ins_cnt = cnt_reg;
        if (cmd.qty == '0)
        begin
            ok  = chain_w[MAX_DEPTH].found;
            act = dlpb_pkg::CELL_DELETE;
        end
        else if (chain_w[MAX_DEPTH].found)
        begin
            ok  = 1'b1;
            act = dlpb_pkg::CELL_OVERWRITE;
        end
        else if (cnt_reg < depth)
        begin
            ok  = 1'b1;
            act = dlpb_pkg::CELL_INSERT;
        end
        else if (chain_w[MAX_DEPTH].better && (cnt_reg != '0))
        begin
            // better than some held level, hence better than the worst one
            ok      = 1'b1;
            evict   = 1'b1;
            act     = dlpb_pkg::CELL_INSERT;
            ins_cnt = cnt_reg - CW'(1);
        end
    end

    assign commit     = cmd.upd_en && ok;
    assign ctrl.op    = commit ? act : dlpb_pkg::CELL_HOLD;
    assign ctrl.sell  = cmd.sell;
    assign ctrl.price = cmd.price;
    assign ctrl.qty   = cmd.qty;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.clear)
            cnt_next = '0;
        else if (commit && (act == dlpb_pkg::CELL_DELETE))
            cnt_next = cnt_reg - CW'(1);
        else if (commit && (act == dlpb_pkg::CELL_INSERT) && !evict)
            cnt_next = cnt_reg + CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    assign stat.ok        = ok;
    assign stat.volume    = chain_w[MAX_DEPTH].vol;
    assign stat.top_valid = cnt_reg != '0;
    assign stat.top_price = (cnt_reg != '0) ? price_w[0] : '0;
    assign stat.top_qty   = (cnt_reg != '0) ? qty_w[0] : '0;
    assign cnt            = cnt_reg;

endmodule

`default_nettype wire

@@ rtl/core/depth_limited_price_level_book_unit.sv @@
// The result beat is presented in the cycle after its request beat is taken.
// Throughput: one item per cycle; every level cell compares, shifts and loads as the
// item is taken, so the row of cells sets the rate, stalled only by the result register.
// Reset: level counts and stored sequence clear to zero, depth register to 16;
// level storage is not reset and needs no clearing pass.
`default_nettype none

module depth_limited_price_level_book_unit #(
    parameter int MAX_DEPTH = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [dlpb_pkg::DEPTH_W-1:0] cfg_wdata,
    input  wire logic                         req_valid,
    output logic                              req_stall,
    input  wire dlpb_pkg::req_t               req,
    output logic                              rsp_valid,
    input  wire logic                         rsp_stall,
    output dlpb_pkg::rsp_t                    rsp
);

    localparam int CW = $clog2(MAX_DEPTH + 1);
    localparam int DW = (CW > dlpb_pkg::DEPTH_W) ? CW : dlpb_pkg::DEPTH_W;

    logic [dlpb_pkg::DEPTH_W-1:0]  depth_reg;
    logic [dlpb_pkg::SEQ_BITS-1:0] seq_reg, seq_next;
    logic                          rsp_valid_reg, rsp_valid_next;
    logic [1:0]                    status_reg, status_next;
    logic [dlpb_pkg::QTY_BITS-1:0] volume_reg, volume_next;

    logic [DW-1:0] dep_ext, dep_clamp;
    logic [CW-1:0] eff_depth;
    logic          accept, seq_ok, side_ok, do_update, do_clear;
    logic [dlpb_pkg::QTY_BITS-1:0] side_vol;

    dlpb_pkg::side_cmd_t  bid_cmd, ask_cmd;
    dlpb_pkg::side_stat_t bid_stat, ask_stat;
    logic [CW-1:0]        bid_cnt, ask_cnt;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    // zero behaves as one, anything past the row as the full row
    assign dep_ext = DW'(depth_reg);
    always_comb
    begin
        if (dep_ext == '0)
            dep_clamp = DW'(1);
        else if (dep_ext > DW'(MAX_DEPTH))
            dep_clamp = DW'(MAX_DEPTH);
        else
            dep_clamp = dep_ext;
    end
    assign eff_depth = CW'(dep_clamp);

    assign seq_ok   = req.seq_in == dlpb_pkg::SEQ_BITS'(seq_reg + 1'b1);
    assign side_ok  = req.side ? ask_stat.ok : bid_stat.ok;
    assign side_vol = req.side ? ask_stat.volume : bid_stat.volume;

    assign do_update = accept && (req.kind == dlpb_pkg::KIND_UPDATE) && seq_ok;
    assign do_clear  = accept && (req.kind == dlpb_pkg::KIND_RESET);

    assign bid_cmd.upd_en = do_update && !req.side;
    assign bid_cmd.clear  = do_clear;
    assign bid_cmd.sell   = 1'b0;
    assign bid_cmd.price  = req.price;
    assign bid_cmd.qty    = req.quantity;

    assign ask_cmd.upd_en = do_update && req.side;
    assign ask_cmd.clear  = do_clear;
    assign ask_cmd.sell   = 1'b1;
    assign ask_cmd.price  = req.price;
    assign ask_cmd.qty    = req.quantity;

    dlpb_side #(.MAX_DEPTH(MAX_DEPTH)) u_bid (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (bid_cmd),
        .depth(eff_depth),
        .stat (bid_stat),
        .cnt  (bid_cnt)
    );

    dlpb_side #(.MAX_DEPTH(MAX_DEPTH)) u_ask (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (ask_cmd),
        .depth(eff_depth),
        .stat (ask_stat),
        .cnt  (ask_cnt)
    );

    always_comb
    begin
        status_next = status_reg;
        volume_next = volume_reg;
        seq_next    = seq_reg;
        if (accept)
        begin
            volume_next = '0;
            case (req.kind)
                dlpb_pkg::KIND_UPDATE:
                begin
                    if (!seq_ok)
                        status_next = dlpb_pkg::STATUS_GAP;
                    else if (side_ok)
                    begin
                        status_next = dlpb_pkg::STATUS_OK;
                        seq_next    = req.seq_in;
                    end
                    else
                        status_next = dlpb_pkg::STATUS_REJECT;
                end
                dlpb_pkg::KIND_QUERY:
                begin
                    status_next = dlpb_pkg::STATUS_OK;
                    volume_next = side_vol;
                end
                dlpb_pkg::KIND_RESET:
                begin
                    status_next = dlpb_pkg::STATUS_OK;
                    seq_next    = req.seq_in;
                end
                default:
                    status_next = dlpb_pkg::STATUS_REJECT;
            endcase
        end
    end

    assign rsp_valid_next = accept || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= dlpb_pkg::DEPTH_RESET;
            seq_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                depth_reg <= cfg_wdata;
            seq_reg       <= seq_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        volume_reg <= volume_next;
    end

    // book state moves only when a new result beat is loaded, so it can drive
    // the held beat directly
    assign rsp_valid          = rsp_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.volume         = volume_reg;
    assign rsp.bid_valid      = bid_stat.top_valid;
    assign rsp.best_bid_price = bid_stat.top_price;
    assign rsp.best_bid_qty   = bid_stat.top_qty;
    assign rsp.ask_valid      = ask_stat.top_valid;
    assign rsp.best_ask_price = ask_stat.top_price;
    assign rsp.best_ask_qty   = ask_stat.top_qty;
    assign rsp.bid_levels     = dlpb_pkg::LEVELS_W'(bid_cnt);
    assign rsp.ask_levels     = dlpb_pkg::LEVELS_W'(ask_cnt);
    assign rsp.seq_out        = seq_reg;

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    localparam int BOOK_DEPTH = 16;
    localparam int WATCHDOG_LIMIT = 1000;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic SIDE_BID = 1'b0;
    localparam logic SIDE_ASK = 1'b1;

    class book_scoreboard;
        logic [dlpb_pkg::PRICE_BITS-1:0] lvl_px [2][BOOK_DEPTH];
        logic [dlpb_pkg::QTY_BITS-1:0]   lvl_qty[2][BOOK_DEPTH];
        int unsigned                     n_lvl[2];
        logic [dlpb_pkg::SEQ_BITS-1:0]   last_seq;
        logic [dlpb_pkg::DEPTH_W-1:0]    depth_reg;
        dlpb_pkg::rsp_t                  awaited_books[$];
        int unsigned                     errors;

        function new();
            n_lvl[0] = 0;
            n_lvl[1] = 0;
            last_seq = '0;
            depth_reg = dlpb_pkg::DEPTH_RESET;
            errors = 0;
        endfunction

        function int find_px(bit sd, logic [dlpb_pkg::PRICE_BITS-1:0] p);
            for (int i = 0; i < n_lvl[sd]; i++)
                if (lvl_px[sd][i] == p)
                    return i;
            return -1;
        endfunction

        // bids rank high first, asks low first
        function bit ahead(bit sd, logic [dlpb_pkg::PRICE_BITS-1:0] a,
                           logic [dlpb_pkg::PRICE_BITS-1:0] b);
            return sd ? (a < b) : (a > b);
        endfunction

        function void drop_at(bit sd, int at);
            for (int i = at; i + 1 < n_lvl[sd]; i++)
            begin
                lvl_px[sd][i]  = lvl_px[sd][i+1];
                lvl_qty[sd][i] = lvl_qty[sd][i+1];
            end
            n_lvl[sd]--;
        endfunction

        function void place(bit sd, logic [dlpb_pkg::PRICE_BITS-1:0] p,
                            logic [dlpb_pkg::QTY_BITS-1:0] q);
            int unsigned pos;
            pos = 0;
            while (pos < n_lvl[sd] && !ahead(sd, p, lvl_px[sd][pos]))
                pos++;
            for (int i = n_lvl[sd]; i > pos; i--)
            begin
                lvl_px[sd][i]  = lvl_px[sd][i-1];
                lvl_qty[sd][i] = lvl_qty[sd][i-1];
            end
            lvl_px[sd][pos]  = p;
            lvl_qty[sd][pos] = q;
            n_lvl[sd]++;
        endfunction

        function bit apply_update(bit sd, logic [dlpb_pkg::PRICE_BITS-1:0] p,
                                  logic [dlpb_pkg::QTY_BITS-1:0] q);
            int at;
            int unsigned lim;
            at = find_px(sd, p);
            lim = (depth_reg == 0) ? 1 : ((depth_reg > BOOK_DEPTH) ? BOOK_DEPTH : depth_reg);
            if (q == 0)
            begin
                if (at < 0)
                    return 1'b0;
                drop_at(sd, at);
                return 1'b1;
            end
            if (at >= 0)
            begin
                lvl_qty[sd][at] = q;
                return 1'b1;
            end
            if (n_lvl[sd] < lim)
            begin
                place(sd, p, q);
                return 1'b1;
            end
            // full: only a strictly better price pushes out the worst level
            if (n_lvl[sd] == 0 || !ahead(sd, p, lvl_px[sd][n_lvl[sd]-1]))
                return 1'b0;
            n_lvl[sd]--;
            place(sd, p, q);
            return 1'b1;
        endfunction

        function dlpb_pkg::rsp_t predict_book(dlpb_pkg::req_t r);
            dlpb_pkg::rsp_t o;
            int at;
            logic [dlpb_pkg::SEQ_BITS-1:0] next_seq;
            o = '0;
            next_seq = last_seq + 32'd1;
            case (r.kind)
                dlpb_pkg::KIND_UPDATE:
                    if (r.seq_in != next_seq)
                        o.status = dlpb_pkg::STATUS_GAP;
                    else if (apply_update(r.side, r.price, r.quantity))
                        last_seq = r.seq_in;
                    else
                        o.status = dlpb_pkg::STATUS_REJECT;
                dlpb_pkg::KIND_QUERY:
                begin
                    at = find_px(r.side, r.price);
                    if (at >= 0)
                        o.volume = lvl_qty[r.side][at];
                end
                dlpb_pkg::KIND_RESET:
                begin
                    n_lvl[0] = 0;
                    n_lvl[1] = 0;
                    last_seq = r.seq_in;
                end
                default:
                    o.status = dlpb_pkg::STATUS_REJECT;
            endcase
            o.bid_valid = (n_lvl[0] != 0);
            o.ask_valid = (n_lvl[1] != 0);
            if (n_lvl[0] != 0)
            begin
                o.best_bid_price = lvl_px[0][0];
                o.best_bid_qty   = lvl_qty[0][0];
            end
            if (n_lvl[1] != 0)
            begin
                o.best_ask_price = lvl_px[1][0];
                o.best_ask_qty   = lvl_qty[1][0];
            end
            o.bid_levels = dlpb_pkg::LEVELS_W'(n_lvl[0]);
            o.ask_levels = dlpb_pkg::LEVELS_W'(n_lvl[1]);
            o.seq_out = last_seq;
            return o;
        endfunction

        function void take_request(dlpb_pkg::req_t r);
            awaited_books.push_back(predict_book(r));
        endfunction

        task flag_mismatch(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task match_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                flag_mismatch($sformatf("%s got %h want %h", name, got, want));
        endtask

        task judge_response(dlpb_pkg::rsp_t got);
            dlpb_pkg::rsp_t want;
            if (awaited_books.size() == 0)
            begin
                flag_mismatch("result beat with nothing outstanding");
                return;
            end
            want = awaited_books.pop_front();
            match_field("status", got.status, want.status);
            match_field("volume", got.volume, want.volume);
            match_field("bid_valid", got.bid_valid, want.bid_valid);
            match_field("best_bid_price", got.best_bid_price, want.best_bid_price);
            match_field("best_bid_qty", got.best_bid_qty, want.best_bid_qty);
            match_field("ask_valid", got.ask_valid, want.ask_valid);
            match_field("best_ask_price", got.best_ask_price, want.best_ask_price);
            match_field("best_ask_qty", got.best_ask_qty, want.best_ask_qty);
            match_field("bid_levels", got.bid_levels, want.bid_levels);
            match_field("ask_levels", got.ask_levels, want.ask_levels);
            match_field("seq_out", got.seq_out, want.seq_out);
        endtask
    endclass

    logic                         clk;
    logic                         rst_n = 1'b0;
    logic                         cfg_we = 1'b0;
    logic [dlpb_pkg::DEPTH_W-1:0] cfg_wdata = '0;
    logic                         req_valid = 1'b0;
    logic                         req_stall;
    dlpb_pkg::req_t               book_req = '0;
    logic                         rsp_valid;
    logic                         rsp_stall = 1'b0;
    dlpb_pkg::rsp_t               book_rsp;

    bit                 calm = 1'b0;
    int unsigned        idle_cycles = 0;
    book_scoreboard     sb = new();

    depth_limited_price_level_book_unit #(
        .MAX_DEPTH (BOOK_DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (book_req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (book_rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side: check each beat taken, stall now and then
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rsp_valid === 1'b1 && rsp_stall == 1'b0)
                sb.judge_response(book_rsp);
            rsp_stall <= (!calm && $urandom_range(99) < 8);
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat moved for %0d cycles", idle_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic put_beat(input dlpb_pkg::req_t r);
        if (!calm && $urandom_range(99) < 8)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(posedge clk);
        end
        book_req  <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        sb.take_request(r);
    endtask

    function automatic dlpb_pkg::req_t make_req(logic [1:0] kind, logic side, logic [31:0] sq,
                                                logic [31:0] px, logic [31:0] qty);
        dlpb_pkg::req_t r;
        r.kind = kind;
        r.side = side;
        r.seq_in = sq;
        r.price = px;
        r.quantity = qty;
        return r;
    endfunction

    task automatic upd(input logic side, input logic [31:0] px, input logic [31:0] qty);
        put_beat(make_req(dlpb_pkg::KIND_UPDATE, side, sb.last_seq + 32'd1, px, qty));
    endtask

    task automatic peek_level(input logic side, input logic [31:0] px);
        put_beat(make_req(dlpb_pkg::KIND_QUERY, side, $urandom, px, $urandom));
    endtask

    task automatic flush_book(input logic [31:0] sq);
        put_beat(make_req(dlpb_pkg::KIND_RESET, $urandom_range(1), sq, $urandom, $urandom));
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (sb.awaited_books.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_depth(input logic [dlpb_pkg::DEPTH_W-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.depth_reg = v;
    endtask

    function automatic logic [31:0] pick_price(bit sd);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 45 && sb.n_lvl[sd] != 0)
            return sb.lvl_px[sd][$urandom_range(sb.n_lvl[sd] - 1)];
        if (r < 88)
            return 32'd1000 + $urandom_range(95);
        if (r < 96)
            return $urandom;
        return r[0] ? 32'hFFFF_FFFF : 32'h0;
    endfunction

    function automatic logic [31:0] pick_qty();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 16)
            return 32'h0;
        if (r < 20)
            return 32'hFFFF_FFFF;
        if (r < 24)
            return 32'h1;
        return $urandom;
    endfunction

    // mostly in-sequence updates so the book fills and evicts; the rest is noise
    task automatic random_beat();
        int unsigned pick;
        bit sd;
        logic [31:0] sq;
        pick = $urandom_range(99);
        sd = $urandom_range(1);
        if (pick < 84)
            upd(sd, pick_price(sd), pick_qty());
        else if (pick < 91)
            peek_level(sd, pick_price(sd));
        else if (pick < 96)
        begin
            case ($urandom_range(2))
                0: sq = sb.last_seq;
                1: sq = sb.last_seq + 32'd2;
                default: sq = $urandom;
            endcase
            if (sq == sb.last_seq + 32'd1)
                sq = sq + 32'd1;
            put_beat(make_req(dlpb_pkg::KIND_UPDATE, sd, sq, pick_price(sd), pick_qty()));
        end
        else if (pick < 98)
            flush_book(($urandom_range(2) == 0) ? 32'hFFFF_FFFF : $urandom);
        else
            put_beat(make_req(KIND_UNUSED, sd, $urandom, $urandom, $urandom));
    endtask

    initial
    begin
        logic [dlpb_pkg::DEPTH_W-1:0] depth_plan[9];
        depth_plan = '{5'd16, 5'd2, 5'd31, 5'd0, 5'd17, 5'd5, 5'd8, 5'd1, 5'd16};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, overwrite, delete, gaps, unused kind, wrap of the sequence
        peek_level(SIDE_BID, 32'h0);
        upd(SIDE_BID, 32'd100, 32'hFFFF_FFFF);
        upd(SIDE_ASK, 32'hFFFF_FFFF, 32'h1);
        upd(SIDE_ASK, 32'h0, 32'd5);
        upd(SIDE_BID, 32'hFFFF_FFFF, 32'd7);
        upd(SIDE_BID, 32'h0, 32'd9);
        upd(SIDE_BID, 32'd100, 32'd33);
        peek_level(SIDE_BID, 32'd100);
        peek_level(SIDE_ASK, 32'hFFFF_FFFF);
        peek_level(SIDE_ASK, 32'd12345);
        upd(SIDE_BID, 32'd100, 32'h0);
        upd(SIDE_BID, 32'd100, 32'h0);
        put_beat(make_req(dlpb_pkg::KIND_UPDATE, SIDE_BID, sb.last_seq + 32'd5, 32'd1, 32'd1));
        put_beat(make_req(dlpb_pkg::KIND_UPDATE, SIDE_ASK, sb.last_seq, 32'd2, 32'd2));
        put_beat(make_req(KIND_UNUSED, SIDE_ASK, $urandom, $urandom, $urandom));
        flush_book(32'hFFFF_FFFF);
        upd(SIDE_ASK, 32'd7, 32'h0);
        upd(SIDE_ASK, 32'd7, 32'd3);

        set_depth(5'd1);
        upd(SIDE_BID, 32'd50, 32'd1);
        upd(SIDE_BID, 32'd40, 32'd2);
        upd(SIDE_BID, 32'd60, 32'd3);
        upd(SIDE_BID, 32'd60, 32'd4);
        upd(SIDE_ASK, 32'd70, 32'd5);
        upd(SIDE_ASK, 32'd6, 32'd6);

        set_depth(5'd0);
        upd(SIDE_BID, 32'd5, 32'd8);
        upd(SIDE_BID, 32'd60, 32'h0);
        upd(SIDE_BID, 32'd10, 32'd1);

        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph == 1)
            begin
                // fill both sides, then drop the depth below what is held
                flush_book($urandom);
                for (int i = 0; i < BOOK_DEPTH; i++)
                begin
                    upd(SIDE_BID, 32'd5000 + i, $urandom | 32'd1);
                    upd(SIDE_ASK, 32'd500 - i, $urandom | 32'd1);
                end
            end
            set_depth(depth_plan[ph]);
            calm = (ph == 4);
            for (int k = 0; k < 100; k++)
                random_beat();
        end
        calm = 1'b0;

        drain();
        repeat (4) @(posedge clk);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
